// ===== rtl/diff_drive_odometry_fusion_macros.svh =====
`ifndef DIFF_DRIVE_ODOMETRY_FUSION_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_FUSION_MACROS_SVH

// Same-cycle implication, checked on i_clk, off while i_rst_n is low.
`define DDO_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DDO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication after a fixed number of cycles.
`define DDO_ASSERT_LATER(label, ante, n, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##n (cons)) \
        else $error(msg);

`endif

// ===== rtl/ddo_pkg.sv =====
package ddo_pkg;

    typedef struct packed {
        logic [31:0] rpm_scale;
        logic [31:0] forward_scale;
        logic [31:0] turn_scale;
        logic [31:0] distance_scale;
        logic [16:0] filter_alpha;
    } t_cfg;

    // operand load: which value goes into the magnitude/scale registers
    typedef enum logic [2:0] {
        OPL_NONE,
        OPL_LEFT,
        OPL_RIGHT,
        OPL_DIST,
        OPL_FWD,
        OPL_TURN,
        OPL_FILT
    } t_opl;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_LO,
        MUL_HI
    } t_mul;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_LOADSH,
        ACC_ADD
    } t_acc;

    typedef enum logic [2:0] {
        FIN_NONE,
        FIN_LRPM,
        FIN_RRPM,
        FIN_FWD,
        FIN_TURN,
        FIN_DIST,
        FIN_FILT
    } t_fin;

    typedef enum logic {
        JMP_NONE,
        JMP_NO_LINE
    } t_jmp;

    localparam int unsigned UPC_W = 4;
    typedef logic [UPC_W-1:0] t_upc;

    typedef struct packed {
        t_opl opl;
        t_mul mul;
        t_acc acc;
        t_fin fin;
        logic yaw_upd;
        t_jmp jmp;
        t_upc target;
        logic last;
    } t_uword;

    typedef struct packed {
        logic [31:0] left_rpm;
        logic [31:0] right_rpm;
        logic [31:0] forward_speed;
        logic [31:0] turn_rate;
        logic [31:0] travelled;
        logic [31:0] yaw_total;
        logic [15:0] line_smoothed;
    } t_result;

endpackage

// ===== rtl/ddo_useq.sv =====
module ddo_useq import ddo_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  logic   i_line_valid,
    input  logic   i_out_free,
    output logic   o_busy,
    output logic   o_finish,
    output t_uword o_uword
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    localparam t_upc UPC_DONE = 4'd14;

    localparam t_uword UWORD_NOP = '{
        opl: OPL_NONE, mul: MUL_NONE, acc: ACC_NONE, fin: FIN_NONE,
        yaw_upd: 1'b0, jmp: JMP_NONE, target: '0, last: 1'b0
    };

    // Each product passes from the magnitude/scale registers through the product
    // register and the accumulator, and a result is written from the accumulator.
    function automatic t_uword ucode(input t_upc pc);
        t_uword w;
        w = UWORD_NOP;
        unique case (pc)
            4'd0: begin
                w.opl = OPL_LEFT;
            end
            4'd1: begin
                w.opl     = OPL_RIGHT;
                w.mul     = MUL_LO;
                w.yaw_upd = 1'b1;
            end
            4'd2: begin
                w.opl = OPL_DIST;
                w.mul = MUL_LO;
                w.acc = ACC_LOAD;
            end
            4'd3: begin
                w.mul = MUL_HI;
                w.acc = ACC_LOAD;
                w.fin = FIN_LRPM;
            end
            4'd4: begin
                w.mul = MUL_LO;
                w.acc = ACC_LOADSH;
                w.fin = FIN_RRPM;
            end
            4'd5: begin
                w.opl = OPL_FWD;
                w.acc = ACC_ADD;
            end
            4'd6: begin
                w.mul = MUL_HI;
                w.fin = FIN_DIST;
            end
            4'd7: begin
                w.opl = OPL_TURN;
                w.mul = MUL_LO;
                w.acc = ACC_LOADSH;
            end
            4'd8: begin
                w.mul = MUL_HI;
                w.acc = ACC_ADD;
            end
            4'd9: begin
                w.opl = OPL_FILT;
                w.mul = MUL_LO;
                w.acc = ACC_LOADSH;
                w.fin = FIN_FWD;
            end
            4'd10: begin
                w.mul = MUL_HI;
                w.acc = ACC_ADD;
            end
            4'd11: begin
                w.mul    = MUL_LO;
                w.acc    = ACC_LOADSH;
                w.fin    = FIN_TURN;
                w.jmp    = JMP_NO_LINE;
                w.target = UPC_DONE;
            end
            4'd12: begin
                w.acc = ACC_ADD;
            end
            4'd13: begin
                w.fin = FIN_FILT;
            end
            UPC_DONE: begin
                w.last = 1'b1;
            end
            default: begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

    t_state r_state, n_state;
    t_upc   r_upc, n_upc;
    t_uword word;

    always_comb begin
        word     = (r_state == ST_RUN) ? ucode(r_upc) : UWORD_NOP;
        n_state  = r_state;
        n_upc    = r_upc;
        o_finish = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_RUN;
                    n_upc   = '0;
                end
            end
            ST_RUN: begin
                if (word.last) begin
                    // hold on the last step until the output register is free
                    if (i_out_free) begin
                        o_finish = 1'b1;
                        n_state  = ST_IDLE;
                    end
                end else if (word.jmp == JMP_NO_LINE && !i_line_valid) begin
                    n_upc = word.target;
                end else begin
                    n_upc = r_upc + 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_upc   <= '0;
        end else begin
            r_state <= n_state;
            r_upc   <= n_upc;
        end
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_uword = word;

endmodule

// ===== rtl/ddo_dpath.sv =====
module ddo_dpath import ddo_pkg::*; #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_cfg               i_cfg,
    input  t_uword             i_uword,
    input  logic signed [15:0] i_left_count_delta,
    input  logic signed [15:0] i_right_count_delta,
    input  logic               i_yaw_valid,
    input  logic        [15:0] i_yaw_angle,
    input  logic               i_line_valid,
    input  logic signed [15:0] i_line_sample,
    output logic               o_line_valid,
    output t_result            o_res
);

    localparam logic signed [16:0] YAW_JUMP_POS = 17'sd27000;
    localparam logic signed [16:0] YAW_JUMP_NEG = -17'sd27000;
    localparam logic signed [31:0] CDEG_PER_REV = 32'sd36000;
    localparam logic signed [15:0] REV_MAX      = 16'sh7FFF;
    localparam logic signed [15:0] REV_MIN      = 16'sh8000;
    localparam logic        [16:0] ALPHA_ONE    = 17'd65536;
    localparam logic        [31:0] S32_MAX      = 32'h7FFF_FFFF;
    localparam logic        [31:0] S32_MIN      = 32'h8000_0000;

    function automatic logic [31:0] sat33(input logic [32:0] v);
        logic [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? S32_MIN : S32_MAX;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // item registers
    logic signed [15:0] r_dl, r_dr, r_sample;
    logic        [15:0] r_angle;
    logic               r_yaw_valid, r_line_valid;

    // running state
    logic signed [31:0] r_lpos, r_rpos, r_last_yaw, r_fv;
    logic        [15:0] r_prev_yaw;
    logic signed [15:0] r_rev;

    // per-item results
    logic [31:0] r_lrpm, r_rrpm, r_fwd, r_turn, r_dist;

    // shared multiply path
    logic [32:0] r_mag;
    logic [31:0] r_scale;
    logic        r_neg;
    logic [48:0] r_prod;
    logic        r_prod_neg;
    logic [64:0] r_acc;
    logic        r_acc_neg;

    logic [32:0]        lpos_sum, rpos_sum;
    logic signed [16:0] yaw_d;
    logic signed [15:0] n_rev;
    logic signed [31:0] yaw_tot;

    always_comb begin
        lpos_sum = {r_lpos[31], r_lpos} + {{17{i_left_count_delta[15]}}, i_left_count_delta};
        rpos_sum = {r_rpos[31], r_rpos} + {{17{i_right_count_delta[15]}}, i_right_count_delta};
        yaw_d    = $signed({1'b0, i_yaw_angle}) - $signed({1'b0, r_prev_yaw});
        n_rev    = r_rev;
        if (yaw_d > YAW_JUMP_POS) begin
            if (r_rev != REV_MIN) n_rev = r_rev - 16'sd1;
        end else if (yaw_d < YAW_JUMP_NEG) begin
            if (r_rev != REV_MAX) n_rev = r_rev + 16'sd1;
        end
        yaw_tot = 32'(r_rev) * CDEG_PER_REV + $signed({16'b0, r_angle});
    end

    // operand select
    logic [32:0] opv, op_mag;
    logic [31:0] op_scale;
    logic [16:0] alpha_eff;

    always_comb begin
        alpha_eff = (i_cfg.filter_alpha > ALPHA_ONE) ? ALPHA_ONE : i_cfg.filter_alpha;
        unique case (i_uword.opl)
            OPL_LEFT: begin
                opv      = {{17{r_dl[15]}}, r_dl};
                op_scale = i_cfg.rpm_scale;
            end
            OPL_RIGHT: begin
                opv      = {{17{r_dr[15]}}, r_dr};
                op_scale = i_cfg.rpm_scale;
            end
            OPL_DIST: begin
                opv      = {r_rpos[31], r_rpos} + {r_lpos[31], r_lpos};
                op_scale = i_cfg.distance_scale;
            end
            OPL_FWD: begin
                opv      = {r_rrpm[31], r_rrpm} + {r_lrpm[31], r_lrpm};
                op_scale = i_cfg.forward_scale;
            end
            OPL_TURN: begin
                opv      = {r_rrpm[31], r_rrpm} - {r_lrpm[31], r_lrpm};
                op_scale = i_cfg.turn_scale;
            end
            OPL_FILT: begin
                // new = fv + floor(alpha * (sample * 2^16 - fv) / 2^16)
                opv      = {r_sample[15], r_sample, 16'h0000} - {r_fv[31], r_fv};
                op_scale = {15'b0, alpha_eff};
            end
            default: begin
                opv      = '0;
                op_scale = '0;
            end
        endcase
        op_mag = opv[32] ? (~opv + 33'd1) : opv;
    end

    // 17 x 32 unsigned multiply, high or low half of the magnitude
    logic [16:0] mul_half;
    logic [48:0] mul_prod;

    always_comb begin
        mul_half = (i_uword.mul == MUL_HI) ? r_mag[32:16] : {1'b0, r_mag[15:0]};
        mul_prod = 49'(mul_half) * 49'(r_scale);
    end

    // result write-back from the accumulator
    logic        fin_frac, fin_big;
    logic [64:0] fin_shr;
    logic [31:0] fin_trunc;
    logic signed [50:0] f_mag, f_sv, f_q;
    logic signed [51:0] f_sum;
    logic [31:0] f_sat;

    always_comb begin
        fin_frac = (i_uword.fin == FIN_FWD) || (i_uword.fin == FIN_TURN);
        fin_shr  = fin_frac ? (r_acc >> FRAC_BITS) : r_acc;
        fin_big  = |fin_shr[64:31];
        if (r_acc_neg) begin
            fin_trunc = fin_big ? S32_MIN : (~fin_shr[31:0] + 32'd1);
        end else begin
            fin_trunc = fin_big ? S32_MAX : fin_shr[31:0];
        end

        f_mag = $signed({1'b0, r_acc[49:0]});
        f_sv  = r_acc_neg ? -f_mag : f_mag;
        f_q   = f_sv >>> 16;
        f_sum = $signed({f_q[50], f_q}) + $signed({{20{r_fv[31]}}, r_fv});
        if (f_sum[51:31] == '0 || f_sum[51:31] == '1) begin
            f_sat = f_sum[31:0];
        end else begin
            f_sat = f_sum[51] ? S32_MIN : S32_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lpos     <= '0;
            r_rpos     <= '0;
            r_prev_yaw <= '0;
            r_rev      <= '0;
            r_last_yaw <= '0;
            r_fv       <= '0;
        end else begin
            if (i_start) begin
                r_lpos <= sat33(lpos_sum);
                r_rpos <= sat33(rpos_sum);
                if (i_yaw_valid) begin
                    r_rev      <= n_rev;
                    r_prev_yaw <= i_yaw_angle;
                end
            end
            if (i_uword.yaw_upd && r_yaw_valid) begin
                r_last_yaw <= yaw_tot;
            end
            if (i_uword.fin == FIN_FILT) begin
                r_fv <= f_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dl         <= i_left_count_delta;
            r_dr         <= i_right_count_delta;
            r_sample     <= i_line_sample;
            r_angle      <= i_yaw_angle;
            r_yaw_valid  <= i_yaw_valid;
            r_line_valid <= i_line_valid;
        end
        if (i_uword.opl != OPL_NONE) begin
            r_mag   <= op_mag;
            r_neg   <= opv[32];
            r_scale <= op_scale;
        end
        if (i_uword.mul != MUL_NONE) begin
            r_prod     <= mul_prod;
            r_prod_neg <= r_neg;
        end
        unique case (i_uword.acc)
            ACC_LOAD: begin
                r_acc     <= 65'(r_prod);
                r_acc_neg <= r_prod_neg;
            end
            ACC_LOADSH: begin
                r_acc     <= {r_prod, 16'h0000};
                r_acc_neg <= r_prod_neg;
            end
            ACC_ADD: begin
                r_acc <= r_acc + 65'(r_prod);
            end
            default: begin
            end
        endcase
        unique case (i_uword.fin)
            FIN_LRPM: r_lrpm <= fin_trunc;
            FIN_RRPM: r_rrpm <= fin_trunc;
            FIN_FWD:  r_fwd  <= fin_trunc;
            FIN_TURN: r_turn <= fin_trunc;
            FIN_DIST: r_dist <= fin_trunc;
            default: begin
            end
        endcase
    end

    assign o_line_valid        = r_line_valid;
    assign o_res.left_rpm      = r_lrpm;
    assign o_res.right_rpm     = r_rrpm;
    assign o_res.forward_speed = r_fwd;
    assign o_res.turn_rate     = r_turn;
    assign o_res.travelled     = r_dist;
    assign o_res.yaw_total     = r_last_yaw;
    assign o_res.line_smoothed = r_fv[31:16];

endmodule

// ===== rtl/diff_drive_odometry_fusion.sv =====
// Differential-drive odometry: wheel rpm, forward speed, turn rate, travelled
// distance, multi-turn yaw and a low-pass filtered line sensor, one result per
// input item.
// Input channel: i_in_valid with the item fields, o_in_stall back. An item is
// taken at an edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid with the result fields, i_out_stall back. The
// result sits in an output register and holds while i_out_stall is high.
// Configuration: i_cfg_valid/o_cfg_ready with i_cfg_index and i_cfg_data;
// 0 rpm_scale, 1 forward_scale, 2 turn_scale, 3 distance_scale,
// 4 filter_alpha, other indexes are ignored. Write only while idle.
// Program: o_in_stall is high after acceptance until the microcode program
// finishes, so a new item is taken only after the last one is done. The
// program skips the filter update when the item had no line sample, and runs
// ten products through one shared 17x32 multiplier.
// If the receiver stalls, the program holds on its last step until the output
// register frees up.
// Reset clears positions, yaw history and filter, loads the register defaults
// and leaves the output channel empty.
module diff_drive_odometry_fusion import ddo_pkg::*; #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_left_count_delta,
    input  logic signed [15:0] i_right_count_delta,
    input  logic               i_yaw_valid,
    input  logic        [15:0] i_yaw_angle,
    input  logic               i_line_valid,
    input  logic signed [15:0] i_line_sample,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_left_rpm,
    output logic signed [31:0] o_right_rpm,
    output logic signed [31:0] o_forward_speed,
    output logic signed [31:0] o_turn_rate,
    output logic signed [31:0] o_travelled,
    output logic signed [31:0] o_yaw_total,
    output logic signed [15:0] o_line_smoothed,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic        [2:0]  i_cfg_index,
    input  logic        [31:0] i_cfg_data
);

    localparam logic [2:0]  CFG_RPM_SCALE      = 3'd0;
    localparam logic [2:0]  CFG_FORWARD_SCALE  = 3'd1;
    localparam logic [2:0]  CFG_TURN_SCALE     = 3'd2;
    localparam logic [2:0]  CFG_DISTANCE_SCALE = 3'd3;
    localparam logic [2:0]  CFG_FILTER_ALPHA   = 3'd4;
    localparam logic [31:0] SCALE_ONE          = 32'd65536;
    localparam logic [16:0] ALPHA_RST          = 17'd16384;

    t_cfg    r_cfg;
    t_result res, r_out;
    t_uword  uword;
    logic    r_out_valid;
    logic    busy, finish, out_free, start, dp_line_valid;

    assign o_cfg_ready = 1'b1;
    assign start       = i_in_valid && !busy;
    assign out_free    = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rpm_scale      <= SCALE_ONE;
            r_cfg.forward_scale  <= SCALE_ONE;
            r_cfg.turn_scale     <= SCALE_ONE;
            r_cfg.distance_scale <= SCALE_ONE;
            r_cfg.filter_alpha   <= ALPHA_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_RPM_SCALE:      r_cfg.rpm_scale      <= i_cfg_data;
                CFG_FORWARD_SCALE:  r_cfg.forward_scale  <= i_cfg_data;
                CFG_TURN_SCALE:     r_cfg.turn_scale     <= i_cfg_data;
                CFG_DISTANCE_SCALE: r_cfg.distance_scale <= i_cfg_data;
                CFG_FILTER_ALPHA:   r_cfg.filter_alpha   <= i_cfg_data[16:0];
                default: begin
                end
            endcase
        end
    end

    ddo_useq u_useq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_line_valid (dp_line_valid),
        .i_out_free   (out_free),
        .o_busy       (busy),
        .o_finish     (finish),
        .o_uword      (uword)
    );

    ddo_dpath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (start),
        .i_cfg               (r_cfg),
        .i_uword             (uword),
        .i_left_count_delta  (i_left_count_delta),
        .i_right_count_delta (i_right_count_delta),
        .i_yaw_valid         (i_yaw_valid),
        .i_yaw_angle         (i_yaw_angle),
        .i_line_valid        (i_line_valid),
        .i_line_sample       (i_line_sample),
        .o_line_valid        (dp_line_valid),
        .o_res               (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out <= res;
        end
    end

    assign o_in_stall      = busy;
    assign o_out_valid     = r_out_valid;
    assign o_left_rpm      = $signed(r_out.left_rpm);
    assign o_right_rpm     = $signed(r_out.right_rpm);
    assign o_forward_speed = $signed(r_out.forward_speed);
    assign o_turn_rate     = $signed(r_out.turn_rate);
    assign o_travelled     = $signed(r_out.travelled);
    assign o_yaw_total     = $signed(r_out.yaw_total);
    assign o_line_smoothed = $signed(r_out.line_smoothed);

endmodule

// ===== rtl/ddo_checker.sv =====
`include "diff_drive_odometry_fusion_macros.svh"

module ddo_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_left_rpm,
    input logic signed [31:0] o_right_rpm,
    input logic signed [31:0] o_forward_speed,
    input logic signed [31:0] o_turn_rate,
    input logic signed [31:0] o_travelled,
    input logic signed [31:0] o_yaw_total,
    input logic signed [15:0] o_line_smoothed
);

    logic in_acc;
    assign in_acc = i_in_valid && !o_in_stall;

    `DDO_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid, "result dropped while stalled")
    `DDO_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_left_rpm) && $stable(o_right_rpm) && $stable(o_forward_speed) && $stable(o_turn_rate) && $stable(o_travelled) && $stable(o_yaw_total) && $stable(o_line_smoothed), "result changed while stalled")
    `DDO_ASSERT_NEXT(a_busy_after_accept, in_acc, o_in_stall, "input not stalled after an item")
    `DDO_ASSERT_LATER(a_min_latency, in_acc, 12, o_in_stall, "item finished too early")

endmodule

bind diff_drive_odometry_fusion ddo_checker u_ddo_checker (.*);
